/* rtl/rcci_pkg.sv */
// Shared types and constants for the row and column checksum inserter.
package rcci_pkg;

  // Width of every running sum, row and column alike.
  localparam int unsigned SumW = 16;

  // Width of one stream byte.
  localparam int unsigned ByteW = 8;

  // Input function codes.
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Kind codes carried with each output beat.
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_PAD     = 2'd1,
    KIND_ROW_SUM = 2'd2,
    KIND_COL_SUM = 2'd3
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROW_LO,
    ST_ROW_HI,
    ST_COL_LO,
    ST_COL_HI
  } state_e;

  // Ring control: shift goes to every column cell, clear and add to the tail cell only.
  typedef struct packed {
    logic             shift;
    logic             clr;
    logic [ByteW-1:0] add;
  } ring_ctrl_t;

endpackage

/* rtl/rcci_cell.sv */
// One column cell: a 16-bit column sum that moves one place along the ring per shift.
module rcci_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             shift_i,
  input  logic                             clr_i,
  input  logic [rcci_pkg::SumW-1:0]        prev_i,
  input  logic [rcci_pkg::ByteW-1:0]       add_i,
  output logic [rcci_pkg::SumW-1:0]        sum_o
);
  import rcci_pkg::*;

  logic [SumW-1:0] sum_d, sum_q;

  // Take the neighbor's sum, plus an optional byte, or clear on the final pass.
  always_comb begin
    sum_d = sum_q;
    if (shift_i) begin
      if (clr_i) begin
        sum_d = '0;
      end else begin
        sum_d = prev_i + {{(SumW-ByteW){1'b0}}, add_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

/* rtl/row_column_checksum_inserter_core.sv */
// Top level of the row and column checksum inserter: sequencer, output register and cell ring.
//
// Bytes are grouped into rows of ROW_BYTES; each row is passed through and followed by its
// 16-bit byte sum, low byte first. The column sums live in a ring of ROW_BYTES+2 cells that
// rotates one place per emitted row byte, so the head cell is always the current column.
// Every output beat passes through the single output register. A data byte that closes a
// row is followed by its two row-sum beats; an end item loads no beat when it is taken, then
// pads a partial row with (ROW_BYTES - filled) zero bytes and its row sum, followed by the
// column sums: low bytes while the ring rotates once, high bytes while it rotates again. No
// new item is accepted until all beats of the current one have been loaded into the output
// register.
module row_column_checksum_inserter_core #(
  parameter int unsigned ROW_BYTES = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [rcci_pkg::ByteW-1:0]    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rcci_pkg::ByteW-1:0]    out_byte_o,
  output logic [1:0]                    byte_kind_o,
  output logic                          last_o
);
  import rcci_pkg::*;

  localparam int unsigned NumCols = ROW_BYTES + 2;
  localparam int unsigned PosW    = $clog2(ROW_BYTES + 1);
  localparam int unsigned CntW    = $clog2(NumCols);
  localparam logic [PosW-1:0] PosLast = PosW'(ROW_BYTES - 1);
  localparam logic [CntW-1:0] CntLast = CntW'(NumCols - 1);

  state_e          state_d, state_q;
  logic [PosW-1:0] pos_d, pos_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic [SumW-1:0] row_sum_d, row_sum_q;
  logic            flush_d, flush_q;

  logic             out_valid_d, out_valid_q;
  logic [ByteW-1:0] out_byte_d, out_byte_q;
  kind_e            kind_d, kind_q;
  logic             last_d, last_q;

  logic             adv;
  logic             in_acc;
  ring_ctrl_t       ring;
  logic [SumW-1:0]  sums [NumCols];
  logic [SumW-1:0]  head;

  // The output register can take a new beat when empty or being drained.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign head       = sums[0];

  // Sequencer: next state, ring control and the next output beat.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    row_sum_d   = row_sum_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    kind_d      = kind_q;
    last_d      = last_q;
    ring        = '{shift: 1'b0, clr: 1'b0, add: '0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (func_i == FUNC_DATA) begin
            out_valid_d = 1'b1;
            out_byte_d  = data_byte_i;
            kind_d      = KIND_DATA;
            last_d      = (pos_q != PosLast);
            ring        = '{shift: 1'b1, clr: 1'b0, add: data_byte_i};
            row_sum_d   = row_sum_q + {{(SumW-ByteW){1'b0}}, data_byte_i};
            if (pos_q == PosLast) begin
              pos_d   = '0;
              state_d = ST_ROW_LO;
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end else begin
            flush_d = 1'b1;
            state_d = (pos_q != '0) ? ST_PAD : ST_COL_LO;
          end
        end
      end

      ST_PAD: begin
        if (adv) begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          kind_d      = KIND_PAD;
          last_d      = 1'b0;
          ring        = '{shift: 1'b1, clr: 1'b0, add: '0};
          if (pos_q == PosLast) begin
            pos_d   = '0;
            state_d = ST_ROW_LO;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end

      ST_ROW_LO: begin
        if (adv) begin
          out_valid_d = 1'b1;
          out_byte_d  = row_sum_q[ByteW-1:0];
          kind_d      = KIND_ROW_SUM;
          last_d      = 1'b0;
          ring        = '{shift: 1'b1, clr: 1'b0, add: row_sum_q[ByteW-1:0]};
          state_d     = ST_ROW_HI;
        end
      end

      ST_ROW_HI: begin
        if (adv) begin
          out_valid_d = 1'b1;
          out_byte_d  = row_sum_q[SumW-1:ByteW];
          kind_d      = KIND_ROW_SUM;
          last_d      = !flush_q;
          ring        = '{shift: 1'b1, clr: 1'b0, add: row_sum_q[SumW-1:ByteW]};
          row_sum_d   = '0;
          state_d     = flush_q ? ST_COL_LO : ST_IDLE;
        end
      end

      ST_COL_LO: begin
        if (adv) begin
          out_valid_d = 1'b1;
          out_byte_d  = head[ByteW-1:0];
          kind_d      = KIND_COL_SUM;
          last_d      = 1'b0;
          ring        = '{shift: 1'b1, clr: 1'b0, add: '0};
          if (cnt_q == CntLast) begin
            cnt_d   = '0;
            state_d = ST_COL_HI;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end

      ST_COL_HI: begin
        if (adv) begin
          out_valid_d = 1'b1;
          out_byte_d  = head[SumW-1:ByteW];
          kind_d      = KIND_COL_SUM;
          last_d      = (cnt_q == CntLast);
          ring        = '{shift: 1'b1, clr: 1'b1, add: '0};
          if (cnt_q == CntLast) begin
            cnt_d   = '0;
            flush_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      row_sum_q   <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      row_sum_q   <= row_sum_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    kind_q     <= kind_d;
    last_q     <= last_d;
  end

  // Ring of column cells; the head wraps to the tail picking up the added byte.
  for (genvar k = 0; k < NumCols; k++) begin : g_cell
    if (k == NumCols - 1) begin : g_tail
      rcci_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring.shift),
        .clr_i   (ring.clr),
        .prev_i  (sums[0]),
        .add_i   (ring.add),
        .sum_o   (sums[k])
      );
    end else begin : g_body
      rcci_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring.shift),
        .clr_i   (1'b0),
        .prev_i  (sums[k+1]),
        .add_i   ({ByteW{1'b0}}),
        .sum_o   (sums[k])
      );
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign byte_kind_o = kind_q;
  assign last_o      = last_q;

endmodule
